>>> design/psf_pkg.sv
package psf_pkg;

  typedef struct packed {
    logic [7:0]  out_char;
    logic        last;
    logic        done_res;
    logic [15:0] total_length;
  } psf_res_t;

  localparam logic [2:0] ACT_FMT  = 3'd0;
  localparam logic [2:0] ACT_VAL  = 3'd1;
  localparam logic [2:0] ACT_STR  = 3'd2;
  localparam logic [2:0] ACT_NULL = 3'd3;
  localparam logic [2:0] ACT_END  = 3'd4;

  localparam logic [2:0] MODE_LITERAL = 3'd0;
  localparam logic [2:0] MODE_PERCENT = 3'd1;
  localparam logic [2:0] MODE_WIDTH   = 3'd2;
  localparam logic [2:0] MODE_NUMBER  = 3'd3;
  localparam logic [2:0] MODE_CHAR    = 3'd4;
  localparam logic [2:0] MODE_STRING  = 3'd5;

  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SPACE = 8'h20;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    digit_char = (d < 4'd10) ? (8'h30 + {4'd0, d}) : (8'h57 + {4'd0, d});
  endfunction

  function automatic logic [7:0] null_char(input logic [2:0] i);
    case (i)
      3'd0:    null_char = 8'h28;
      3'd1:    null_char = 8'h6e;
      3'd2:    null_char = 8'h75;
      3'd3:    null_char = 8'h6c;
      3'd4:    null_char = 8'h6c;
      default: null_char = 8'h29;
    endcase
  endfunction

endpackage

>>> design/psf_if.sv
interface psf_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [7:0]  char_in;
  logic [31:0] arg_value;
  modport source (output valid, action, char_in, arg_value, input ready);
  modport sink (input valid, action, char_in, arg_value, output ready);
endinterface

interface psf_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_char;
  logic        last;
  logic        done_res;
  logic [15:0] total_length;
  modport source (output valid, out_char, last, done_res, total_length, input ready);
  modport sink (input valid, out_char, last, done_res, total_length, output ready);
endinterface

>>> design/printf_style_formatter_top.sv
// Channel | dir | payload
// in_     | in  | action[2:0], char_in[7:0], arg_value[31:0]
// out_    | out | out_char[7:0], last, done_res, total_length[15:0]
// A numeric argument first runs the digit unit, one digit a cycle (up to 10
// decimal or 8 hex), then sizes the field and emits max(digits, width)
// characters.
// Reset is synchronous, active low, and returns to literal mode, count zero.
// A stalled output holds the sequencer; no input is taken until done.
module printf_style_formatter_top #(
  parameter int MAX_FIELD_WIDTH = 16,
  parameter int COUNT_BITS      = 16
) (
  input logic clk,
  input logic rst_n,
  psf_in_if.sink    in_ch,
  psf_out_if.source out_ch
);
  localparam int WB = $clog2(MAX_FIELD_WIDTH + 1) + 1;
  localparam logic [2:0] S_IDLE = 3'd0, S_EMIT = 3'd1, S_CONV = 3'd2, S_NUM = 3'd3;
  localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};
  localparam logic [7:0] CH_ZERO_L = psf_pkg::CH_ZERO;

  logic [2:0] st_r, st_nxt;
  logic [2:0] mode_r, mode_nxt;
  logic pad_r, pad_nxt, hex_r, hex_nxt;
  logic [WB-1:0] fw_r, fw_nxt;
  logic [COUNT_BITS-1:0] cnt_r;
  // pending emission queue: up to 6 simple characters; the terminator is flagged separately
  logic [7:0] q_r [7];
  logic [7:0] q_nxt [7];
  logic [2:0] qn_r, qn_nxt, qi_r, qi_nxt;
  logic term_r, term_nxt;
  logic [5:0] ni_r, ni_nxt, ntot_r, ntot_nxt;
  logic [7:0] wc;
  logic [WB+3:0] wcalc;
  logic dstart, dbusy;
  logic [4:0] ndig;
  logic [3:0] rdig, ridx;
  logic [7:0] ochar;
  logic olast, odone, ofire, emit_chr;

  psf_digit_unit u_dig (.clk(clk), .rst_n(rst_n), .start(dstart), .hex(hex_r),
    .value(in_ch.arg_value), .rd_idx(ridx), .busy(dbusy), .ndig(ndig), .rd_digit(rdig));

  assign in_ch.ready = (st_r == S_IDLE);
  wire acc = in_ch.valid && in_ch.ready;
  assign wc    = in_ch.char_in;
  assign wcalc = (WB+4)'(fw_r) * (WB+4)'(10) + (WB+4)'(wc - psf_pkg::CH_ZERO);
  assign dstart = acc && in_ch.action == psf_pkg::ACT_VAL && mode_r == psf_pkg::MODE_NUMBER;

  // Select the current output character
  logic [5:0] pos;
  assign pos  = ntot_r - 6'd1 - ni_r;
  assign ridx = pos[3:0];
  always_comb begin
    olast = 1'b0; odone = 1'b0; ochar = 8'd0; emit_chr = 1'b0;
    if (st_r == S_EMIT) begin
      if (qi_r < qn_r) begin
        ochar = q_r[qi_r]; emit_chr = 1'b1;
        olast = (qi_r == qn_r - 3'd1) && !term_r;
      end else begin
        odone = 1'b1; olast = 1'b1;
      end
    end else if (st_r == S_NUM) begin
      emit_chr = 1'b1;
      olast = (ni_r == ntot_r - 6'd1);
      if (pos < {1'b0, ndig}) ochar = psf_pkg::digit_char(rdig);
      else ochar = pad_r ? CH_ZERO_L : psf_pkg::CH_SPACE;
    end
  end

  assign out_ch.valid = (st_r == S_EMIT) || (st_r == S_NUM);
  assign ofire = out_ch.valid && out_ch.ready;
  logic [COUNT_BITS-1:0] cnt_inc;
  assign cnt_inc = (cnt_r == CMAX) ? cnt_r : cnt_r + 1'b1;
  assign out_ch.out_char = ochar;
  assign out_ch.last = olast;
  assign out_ch.done_res = odone;
  assign out_ch.total_length = (emit_chr ? cnt_inc : cnt_r) > COUNT_BITS'(16'hFFFF)
    ? 16'hFFFF : 16'(emit_chr ? cnt_inc : cnt_r);

  // Parse the accepted item and sequence emission
  always_comb begin
    st_nxt = st_r; mode_nxt = mode_r; pad_nxt = pad_r; hex_nxt = hex_r; fw_nxt = fw_r;
    qn_nxt = qn_r; qi_nxt = qi_r; term_nxt = term_r; ni_nxt = ni_r; ntot_nxt = ntot_r;
    for (int k = 0; k < 7; k++) q_nxt[k] = q_r[k];
    if (acc) begin
      qn_nxt = 3'd0; qi_nxt = 3'd0; term_nxt = 1'b0;
      case (in_ch.action)
        psf_pkg::ACT_FMT: if (wc != 8'd0) begin
          logic [2:0] m;
          m = mode_r;
          if (m == psf_pkg::MODE_NUMBER || m == psf_pkg::MODE_CHAR ||
              m == psf_pkg::MODE_STRING) begin
            m = psf_pkg::MODE_LITERAL; pad_nxt = 1'b0; fw_nxt = '0; hex_nxt = 1'b0;
          end
          mode_nxt = m;
          if (m == psf_pkg::MODE_LITERAL) begin
            if (wc == psf_pkg::CH_PCT) mode_nxt = psf_pkg::MODE_PERCENT;
            else begin q_nxt[0] = wc; qn_nxt = 3'd1; end
          end else if (m == psf_pkg::MODE_PERCENT && wc == psf_pkg::CH_ZERO) begin
            pad_nxt = 1'b1; mode_nxt = psf_pkg::MODE_WIDTH;
          end else if (wc >= 8'h30 && wc <= 8'h39) begin
            fw_nxt = (wcalc > (WB+4)'(MAX_FIELD_WIDTH)) ? WB'(MAX_FIELD_WIDTH) : WB'(wcalc);
            mode_nxt = psf_pkg::MODE_WIDTH;
          end else begin
            case (wc)
              8'h64, 8'h75: begin hex_nxt = 1'b0; mode_nxt = psf_pkg::MODE_NUMBER; end
              8'h78: begin hex_nxt = 1'b1; mode_nxt = psf_pkg::MODE_NUMBER; end
              8'h73: mode_nxt = psf_pkg::MODE_STRING;
              8'h63: mode_nxt = psf_pkg::MODE_CHAR;
              psf_pkg::CH_PCT: begin
                q_nxt[0] = psf_pkg::CH_PCT; qn_nxt = 3'd1;
                mode_nxt = psf_pkg::MODE_LITERAL; pad_nxt = 1'b0; fw_nxt = '0;
                hex_nxt = 1'b0;
              end
              default: begin
                q_nxt[0] = psf_pkg::CH_PCT; q_nxt[1] = wc; qn_nxt = 3'd2;
                mode_nxt = psf_pkg::MODE_LITERAL; pad_nxt = 1'b0; fw_nxt = '0;
                hex_nxt = 1'b0;
              end
            endcase
          end
          if (qn_nxt != 3'd0) st_nxt = S_EMIT;
        end
        psf_pkg::ACT_VAL: begin
          if (mode_r == psf_pkg::MODE_NUMBER) st_nxt = S_CONV;
          else if (mode_r == psf_pkg::MODE_CHAR) begin
            q_nxt[0] = in_ch.arg_value[7:0]; qn_nxt = 3'd1; st_nxt = S_EMIT;
            mode_nxt = psf_pkg::MODE_LITERAL; pad_nxt = 1'b0; fw_nxt = '0; hex_nxt = 1'b0;
          end
        end
        psf_pkg::ACT_STR: if (mode_r == psf_pkg::MODE_STRING) begin
          if (wc == 8'd0) begin
            mode_nxt = psf_pkg::MODE_LITERAL; pad_nxt = 1'b0; fw_nxt = '0; hex_nxt = 1'b0;
          end else begin q_nxt[0] = wc; qn_nxt = 3'd1; st_nxt = S_EMIT; end
        end
        psf_pkg::ACT_NULL: if (mode_r == psf_pkg::MODE_STRING) begin
          for (int k = 0; k < 6; k++) q_nxt[k] = psf_pkg::null_char(3'(k));
          qn_nxt = 3'd6; st_nxt = S_EMIT;
          mode_nxt = psf_pkg::MODE_LITERAL; pad_nxt = 1'b0; fw_nxt = '0; hex_nxt = 1'b0;
        end
        psf_pkg::ACT_END: begin
          if (mode_r == psf_pkg::MODE_PERCENT || mode_r == psf_pkg::MODE_WIDTH) begin
            q_nxt[0] = psf_pkg::CH_PCT; qn_nxt = 3'd1;
          end
          term_nxt = 1'b1; st_nxt = S_EMIT;
        end
        default: ;
      endcase
    end else if (st_r == S_CONV) begin
      if (!dbusy) begin
        ntot_nxt = ({1'b0, ndig} > 6'(fw_r)) ? {1'b0, ndig} : 6'(fw_r);
        ni_nxt = 6'd0; st_nxt = S_NUM;
      end
    end else if (ofire) begin
      if (st_r == S_NUM) begin
        ni_nxt = ni_r + 6'd1;
        if (olast) begin
          st_nxt = S_IDLE;
          mode_nxt = psf_pkg::MODE_LITERAL; pad_nxt = 1'b0; fw_nxt = '0; hex_nxt = 1'b0;
        end
      end else begin
        qi_nxt = qi_r + 3'd1;
        if (olast) begin
          st_nxt = S_IDLE;
          if (odone) begin
            mode_nxt = psf_pkg::MODE_LITERAL; pad_nxt = 1'b0; fw_nxt = '0;
            hex_nxt = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; mode_r <= psf_pkg::MODE_LITERAL; pad_r <= 1'b0; hex_r <= 1'b0;
      fw_r <= '0; cnt_r <= '0; qn_r <= 3'd0; qi_r <= 3'd0; term_r <= 1'b0;
      ni_r <= 6'd0; ntot_r <= 6'd0;
    end else begin
      st_r <= st_nxt; mode_r <= mode_nxt; pad_r <= pad_nxt; hex_r <= hex_nxt;
      fw_r <= fw_nxt; qn_r <= qn_nxt; qi_r <= qi_nxt; term_r <= term_nxt;
      ni_r <= ni_nxt; ntot_r <= ntot_nxt;
      if (ofire && odone) cnt_r <= '0;
      else if (ofire && emit_chr) cnt_r <= cnt_inc;
    end
    for (int k = 0; k < 7; k++) q_r[k] <= q_nxt[k];
  end

  // Check sequencer consistency
  a_no_ready_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE) |-> !in_ch.ready) else $error("ready while busy");
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.done_res) |-> out_ch.last) else $error("done without last");
  a_cnt_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (ofire && odone) |=> (cnt_r == '0)) else $error("count not cleared");
  a_num_len: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_NUM) |-> (ntot_r <= 6'd32)) else $error("number too long");
endmodule

>>> design/psf_digit_unit.sv
// Shared digit extractor: one divide-by-radix step per cycle, digits kept
// least significant first in a small register file.
module psf_digit_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        hex,
  input  logic [31:0] value,
  input  logic [3:0]  rd_idx,
  output logic        busy,
  output logic [4:0]  ndig,
  output logic [3:0]  rd_digit
);
  logic [31:0] val_r, val_nxt;
  logic [4:0]  ndig_r, ndig_nxt;
  logic        busy_r, busy_nxt;
  logic        hex_r;
  logic [3:0]  dig_r [16];
  logic [31:0] quot;
  logic [3:0]  rem;
  logic [63:0] prod;

  // Divide by 16 through a shift, or by ten through reciprocal multiply; remainder by back-subtraction
  assign prod = {32'd0, val_r} * 64'hCCCCCCCD;
  always_comb begin
    if (hex_r) begin
      quot = {4'd0, val_r[31:4]};
      rem  = val_r[3:0];
    end else begin
      quot = {3'd0, prod[63:35]};
      rem  = 4'(val_r - quot * 32'd10);
    end
  end

  // Advance one digit a cycle until the value is spent
  always_comb begin
    val_nxt  = val_r;
    ndig_nxt = ndig_r;
    busy_nxt = busy_r;
    if (start) begin
      val_nxt  = value;
      ndig_nxt = 5'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      val_nxt  = quot;
      ndig_nxt = ndig_r + 5'd1;
      busy_nxt = (quot != 32'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ndig_r <= 5'd0;
    end else begin
      busy_r <= busy_nxt;
      ndig_r <= ndig_nxt;
    end
    val_r <= val_nxt;
    if (start) hex_r <= hex;
    if (busy_r && !start) dig_r[ndig_r[3:0]] <= rem;
  end

  assign busy     = busy_r;
  assign ndig     = ndig_r;
  assign rd_digit = dig_r[rd_idx];
endmodule
